// ===== hdl/meg_pkg.sv =====
// Shared constants, types and helper functions for the multipoint envelope generator.
package meg_pkg;

  // Table size and phase format.
  localparam int MAX_POINTS      = 64;
  localparam int PHASE_FRAC_BITS = 24;

  // Field widths.
  localparam int LVL_W  = 24;
  localparam int INC_W  = 25;
  localparam int STR_W  = 24;
  localparam int CNT_W  = 7;
  localparam int SEG_W  = 6;
  localparam int WORD_W = LVL_W + INC_W;

  // RAM address width and the wider width used for point numbers that may
  // point one beyond the table.
  localparam int RA_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int XA_W = (RA_W + 1 > CNT_W) ? RA_W + 1 : CNT_W;

  // Largest usable point count.
  localparam int CNT_LIM = (MAX_POINTS < 64) ? MAX_POINTS : 64;

  // Conversion from Q0.24 increments to the phase format.
  localparam int PH_SHL = (PHASE_FRAC_BITS >= 24) ? PHASE_FRAC_BITS - 24 : 0;
  localparam int PH_SHR = (PHASE_FRAC_BITS < 24) ? 24 - PHASE_FRAC_BITS : 0;

  // Phase sum width covers the largest scaled release step plus the phase.
  localparam int RP_W  = INC_W + STR_W;
  localparam int SUM_W = RP_W - 16 + PH_SHL + 1;
  localparam logic [SUM_W-1:0] PH_ONE = SUM_W'(1) << PHASE_FRAC_BITS;

  // Interpolation product: signed difference times unsigned phase.
  localparam int DIFF_W = LVL_W + 1;
  localparam int MUL_W  = DIFF_W + PHASE_FRAC_BITS + 1;
  localparam int QM_W   = MUL_W - PHASE_FRAC_BITS;

  localparam logic [INC_W-1:0] INC_ONE = INC_W'(1) << 24;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LOAD    = 2'd2,
    KIND_START   = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_POINT_COUNT    = 2'd0,
    REG_SUSTAIN_POINT  = 2'd1,
    REG_FORCED_RELEASE = 2'd2,
    REG_STRETCH        = 2'd3
  } reg_idx_t;

  // Refresh sequencer states.
  typedef enum logic [3:0] {
    SEQ_RUN = 4'b0001,
    SEQ_PT  = 4'b0010,
    SEQ_FIX = 4'b0100,
    SEQ_TGT = 4'b1000
  } seq_t;

  typedef struct packed {
    logic [CNT_W-1:0] point_count;
    logic [SEG_W-1:0] sustain_point;
    logic             forced_release;
    logic [STR_W-1:0] stretch;
  } cfg_t;

  // A point load travelling from the input side into the table.
  typedef struct packed {
    logic              en;
    logic [SEG_W-1:0]  idx;
    logic [WORD_W-1:0] word;
  } load_t;

  // Table values the step logic needs for the current item.
  typedef struct packed {
    logic signed [LVL_W-1:0] l_cur;
    logic signed [LVL_W-1:0] l_prv;
    logic signed [LVL_W-1:0] l_fin;
    logic signed [LVL_W-1:0] l_sus;
    logic signed [LVL_W-1:0] l_tgt;
    logic [INC_W-1:0]        i_tgt;
    logic [INC_W-1:0]        act;
  } view_t;

  typedef struct packed {
    logic signed [LVL_W-1:0] level;
    logic                    done;
    logic [SEG_W-1:0]        segment;
  } result_t;

  // Point count clamped to the usable range.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] pc);
    logic [CNT_W-1:0] c;
    c = pc;
    if (c == '0) begin
      c = CNT_W'(1);
    end
    if (c > CNT_W'(CNT_LIM)) begin
      c = CNT_W'(CNT_LIM);
    end
    return c;
  endfunction

  function automatic logic in_table(input logic [XA_W-1:0] addr);
    return addr < XA_W'(MAX_POINTS);
  endfunction

  // Level of a table word; entries beyond the table read as zero.
  function automatic logic signed [LVL_W-1:0] word_level(input logic [WORD_W-1:0] w,
                                                         input logic [XA_W-1:0]   addr);
    return in_table(addr) ? w[WORD_W-1:INC_W] : '0;
  endfunction

  // Increment of a table word; point zero always reads as one whole step.
  function automatic logic [INC_W-1:0] word_inc(input logic [WORD_W-1:0] w,
                                                input logic [XA_W-1:0]   addr);
    logic [INC_W-1:0] r;
    if (addr == '0) begin
      r = INC_ONE;
    end else if (in_table(addr)) begin
      r = w[INC_W-1:0];
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/multipoint_envelope_generator_core.sv =====
// Top level of the multipoint envelope generator.
//
// Input channel (item_valid / item_stall) takes one word per cycle while
// item_stall is low: a tick, a key release, a point load or a note start.
// Each tick yields exactly one result word (level, done_res, segment) on
// the output channel (result_valid / result_stall); the other kinds yield
// none. A tick's result is registered before it appears on the output.
// Throughput is one word per cycle while item_stall is low. A point change
// (a segment end, the end of the release ramp or a note start) reads the
// new point pair from the table RAM, which holds item_stall high meanwhile.
// A configuration write refreshes the cached levels and release increment
// under a stall, and after reset the block stalls while that refresh runs;
// the registers take their reset values and the point table is undefined
// until loaded. When the receiver stalls, one further result is held in a
// skid stage; after that item_stall stays high until the output drains.
module multipoint_envelope_generator_core
  import meg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [1:0]              kind,
  input  logic [SEG_W-1:0]        point_index,
  input  logic signed [LVL_W-1:0] point_level,
  input  logic [INC_W-1:0]        point_increment,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [LVL_W-1:0] level,
  output logic                    done_res,
  output logic [SEG_W-1:0]        segment,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [STR_W-1:0]        cfg_data
);

  cfg_t             cfg;
  load_t            ld;
  view_t            view;
  result_t          res, result;
  logic             item_acc, cache_ready, skid_valid, rq, push;
  logic [SEG_W-1:0] cur;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.point_count    <= CNT_W'(4);
      cfg.sustain_point  <= '0;
      cfg.forced_release <= 1'b0;
      cfg.stretch        <= STR_W'(65536);
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_POINT_COUNT:    cfg.point_count    <= cfg_data[CNT_W-1:0];
        REG_SUSTAIN_POINT:  cfg.sustain_point  <= cfg_data[SEG_W-1:0];
        REG_FORCED_RELEASE: cfg.forced_release <= cfg_data[0];
        REG_STRETCH:        cfg.stretch        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input handshake.
  assign item_stall = !cache_ready || skid_valid;
  assign item_acc   = item_valid && !item_stall;

  assign ld.en   = item_acc && (kind_t'(kind) == KIND_LOAD);
  assign ld.idx  = point_index;
  assign ld.word = {point_level, point_increment};

  meg_cache u_cache (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_write (cfg_write),
    .cur       (cur),
    .rq        (rq),
    .ld        (ld),
    .ready     (cache_ready),
    .view      (view)
  );

  meg_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .item_acc (item_acc),
    .kind     (kind_t'(kind)),
    .cfg      (cfg),
    .view     (view),
    .cur      (cur),
    .rq       (rq),
    .push     (push),
    .res      (res)
  );

  meg_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .res          (res),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .skid_valid   (skid_valid)
  );

  assign level    = result.level;
  assign done_res = result.done;
  assign segment  = result.segment;

endmodule

// ===== hdl/meg_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module meg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr_b,
  output logic [WIDTH-1:0]                 rd_data_a,
  output logic [WIDTH-1:0]                 rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== hdl/meg_cache.sv =====
// Point table RAM with a register cache of the entries the step logic reads.
module meg_cache
  import meg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             cfg_write,
  input  logic [SEG_W-1:0] cur,
  input  logic             rq,
  input  load_t            ld,
  output logic             ready,
  output view_t            view
);

  seq_t state, state_next;
  seq_t fill;
  logic cfg_pend;
  logic act_pend;

  logic signed [LVL_W-1:0] l_cur, l_prv, l_fin, l_sus, l_tgt;
  logic [INC_W-1:0]        i_tgt, act;

  logic [CNT_W-1:0]  cnt;
  logic [XA_W-1:0]   a_cur, a_prv, a_fin, a_sus, a_tgt, ld_addr;
  logic [XA_W-1:0]   rd_a, rd_b;
  logic [WORD_W-1:0] q_a, q_b;
  logic              ld_ok;

  // Table addresses of every cached entry.
  always_comb begin
    cnt   = eff_count(cfg.point_count);
    a_cur = XA_W'(cur);
    a_prv = (cur == '0) ? '0 : XA_W'(cur) - XA_W'(1);
    a_fin = XA_W'(cnt) - XA_W'(1);
    a_sus = XA_W'(cfg.sustain_point);
    a_tgt = (cfg.sustain_point == '0) ? a_fin : XA_W'(cfg.sustain_point) + XA_W'(1);
  end

  // Refresh sequencer: a PT read for the current pair, then FIX and TGT
  // reads after a configuration change.
  always_comb begin
    state_next = state;
    case (state)
      SEQ_RUN: begin
        if (rq || cfg_pend) begin
          state_next = SEQ_PT;
        end
      end
      SEQ_PT:  state_next = cfg_pend ? SEQ_FIX : SEQ_RUN;
      SEQ_FIX: state_next = SEQ_TGT;
      SEQ_TGT: state_next = SEQ_RUN;
      default: state_next = SEQ_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= SEQ_RUN;
      fill     <= SEQ_RUN;
      cfg_pend <= 1'b1;
      act_pend <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= state;
      if (cfg_write) begin
        cfg_pend <= 1'b1;
      end else if (state == SEQ_PT) begin
        cfg_pend <= 1'b0;
      end
      if (rq) begin
        act_pend <= 1'b1;
      end else if (fill == SEQ_PT) begin
        act_pend <= 1'b0;
      end
    end
  end

  assign ready = (state == SEQ_RUN) && !cfg_pend;

  // Read addresses for the refresh step in progress.
  always_comb begin
    case (state)
      SEQ_FIX: begin
        rd_a = a_fin;
        rd_b = a_sus;
      end
      SEQ_TGT: begin
        rd_a = a_tgt;
        rd_b = a_tgt;
      end
      default: begin
        rd_a = a_cur;
        rd_b = a_prv;
      end
    endcase
  end

  assign ld_addr = XA_W'(ld.idx);
  assign ld_ok   = ld.en && in_table(ld_addr);

  meg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk       (clk),
    .wr_en     (ld_ok),
    .wr_addr   (RA_W'(ld_addr)),
    .wr_data   (ld.word),
    .rd_addr_a (RA_W'(rd_a)),
    .rd_addr_b (RA_W'(rd_b)),
    .rd_data_a (q_a),
    .rd_data_b (q_b)
  );

  // Cached values, taken straight from the RAM in the cycle they arrive.
  always_comb begin
    view.l_cur = (fill == SEQ_PT)  ? word_level(q_a, a_cur) : l_cur;
    view.l_prv = (fill == SEQ_PT)  ? word_level(q_b, a_prv) : l_prv;
    view.l_fin = (fill == SEQ_FIX) ? word_level(q_a, a_fin) : l_fin;
    view.l_sus = (fill == SEQ_FIX) ? word_level(q_b, a_sus) : l_sus;
    view.l_tgt = (fill == SEQ_TGT) ? word_level(q_a, a_tgt) : l_tgt;
    view.i_tgt = (fill == SEQ_TGT) ? word_inc(q_a, a_tgt)   : i_tgt;
    view.act   = (fill == SEQ_PT && act_pend) ? word_inc(q_a, a_cur) : act;
  end

  // Cache registers; a point load that hits a cached entry overwrites it.
  always_ff @(posedge clk) begin
    l_cur <= (ld_ok && ld_addr == a_cur) ? word_level(ld.word, a_cur) : view.l_cur;
    l_prv <= (ld_ok && ld_addr == a_prv) ? word_level(ld.word, a_prv) : view.l_prv;
    l_fin <= (ld_ok && ld_addr == a_fin) ? word_level(ld.word, a_fin) : view.l_fin;
    l_sus <= (ld_ok && ld_addr == a_sus) ? word_level(ld.word, a_sus) : view.l_sus;
    l_tgt <= (ld_ok && ld_addr == a_tgt) ? word_level(ld.word, a_tgt) : view.l_tgt;
    i_tgt <= (ld_ok && ld_addr == a_tgt) ? word_inc(ld.word, a_tgt)   : view.i_tgt;
  end

  // The active increment is latched only when the point changes.
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= '0;
    end else begin
      act <= view.act;
    end
  end

  // A point change is always followed by a read of the new pair.
  a_rq_refresh: assert property (@(posedge clk) disable iff (rst)
    rq |=> state == SEQ_PT)
    else $error("point change not followed by a refresh read");

  // A pending increment reload is served by the very next data word.
  a_act_served: assert property (@(posedge clk) disable iff (rst)
    act_pend |-> (state == SEQ_PT) || (fill == SEQ_PT))
    else $error("increment reload left pending");

endmodule

// ===== hdl/meg_engine.sv =====
// Envelope state and the combinational tick, release and note start logic.
module meg_engine
  import meg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_acc,
  input  kind_t            kind,
  input  cfg_t             cfg,
  input  view_t            view,
  output logic [SEG_W-1:0] cur,
  output logic             rq,
  output logic             push,
  output result_t          res
);

  logic [PHASE_FRAC_BITS-1:0] phase, phase_next;
  logic signed [LVL_W-1:0]    last, last_next;
  logic [SEG_W-1:0]           cur_next;
  logic                       released, released_next;
  logic                       pend, pend_next;
  logic                       finished, finished_next;

  logic [CNT_W-1:0]  cnt, cnt_m1, np;
  logic [SEG_W-1:0]  np_sat;
  logic              hold, ramp, wrap;

  logic signed [LVL_W-1:0]     ia, ib, lv, lerp;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [PHASE_FRAC_BITS:0] ph_s;
  logic signed [MUL_W-1:0]     prod;
  logic [MUL_W-1:0]            pabs;
  logic [QM_W-1:0]             qmag, q;
  logic [QM_W-1:0]             ival;
  logic [RP_W-1:0]             rprod;
  logic [SUM_W-1:0]            step_n, step_r, psum;

  // Segment decode.
  always_comb begin
    cnt    = eff_count(cfg.point_count);
    cnt_m1 = cnt - CNT_W'(1);
    hold   = (cfg.sustain_point != '0) && !released &&
             (CNT_W'(cur) == CNT_W'(cfg.sustain_point) + CNT_W'(1));
    ramp   = released && pend;
    np     = (cfg.sustain_point == '0) ? CNT_W'(1) : CNT_W'(cfg.sustain_point) + CNT_W'(2);
    np_sat = (np > CNT_W'(63)) ? SEG_W'(63) : np[SEG_W-1:0];
  end

  // Linear interpolation, product truncated toward zero.
  always_comb begin
    ia    = ramp ? last : view.l_prv;
    ib    = ramp ? view.l_tgt : view.l_cur;
    diff  = {ib[LVL_W-1], ib} - {ia[LVL_W-1], ia};
    ph_s  = {1'b0, phase};
    prod  = diff * ph_s;
    pabs  = prod[MUL_W-1] ? -prod : prod;
    qmag  = pabs[MUL_W-1:PHASE_FRAC_BITS];
    q     = prod[MUL_W-1] ? -qmag : qmag;
    ival  = {{(QM_W-LVL_W){ia[LVL_W-1]}}, ia} + q;
    lerp  = ival[LVL_W-1:0];
  end

  // Phase advance: plain increment, or the release increment scaled by stretch.
  always_comb begin
    rprod  = view.i_tgt * cfg.stretch;
    step_r = (SUM_W'(rprod[RP_W-1:16]) << PH_SHL) >> PH_SHR;
    step_n = (SUM_W'(view.act) << PH_SHL) >> PH_SHR;
    psum   = SUM_W'(phase) + (ramp ? step_r : step_n);
    wrap   = psum >= PH_ONE;
  end

  // Next state for the accepted word.
  always_comb begin
    phase_next    = phase;
    last_next     = last;
    cur_next      = cur;
    released_next = released;
    pend_next     = pend;
    finished_next = finished;
    lv            = view.l_cur;
    rq            = 1'b0;
    push          = 1'b0;
    if (item_acc) begin
      case (kind)
        KIND_TICK: begin
          push = 1'b1;
          if (finished) begin
            lv        = view.l_fin;
            last_next = lv;
          end else if (hold) begin
            lv        = view.l_sus;
            last_next = lv;
          end else if (ramp) begin
            lv = (view.i_tgt == '0) ? view.l_tgt : lerp;
            if (wrap) begin
              rq            = 1'b1;
              pend_next     = 1'b0;
              phase_next    = '0;
              finished_next = (np >= cnt) || (cfg.sustain_point == '0);
              cur_next      = np_sat;
            end else begin
              phase_next = psum[PHASE_FRAC_BITS-1:0];
            end
          end else begin
            lv = (view.act >= INC_ONE) ? view.l_cur : lerp;
            if (wrap) begin
              rq         = 1'b1;
              phase_next = '0;
              if (CNT_W'(cur) >= cnt_m1) begin
                finished_next = 1'b1;
              end else begin
                cur_next = cur + SEG_W'(1);
              end
            end else begin
              phase_next = psum[PHASE_FRAC_BITS-1:0];
            end
            last_next = lv;
          end
        end
        KIND_RELEASE: begin
          if (!released) begin
            released_next = 1'b1;
            if (pend) begin
              phase_next = '0;
            end
          end
        end
        KIND_START: begin
          rq            = 1'b1;
          cur_next      = SEG_W'(1);
          phase_next    = '0;
          released_next = 1'b0;
          finished_next = 1'b0;
          last_next     = '0;
          pend_next     = cfg.forced_release;
        end
        default: begin
          // Point loads go straight to the table.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      last     <= '0;
      cur      <= SEG_W'(1);
      released <= 1'b0;
      pend     <= 1'b0;
      finished <= 1'b0;
    end else begin
      phase    <= phase_next;
      last     <= last_next;
      cur      <= cur_next;
      released <= released_next;
      pend     <= pend_next;
      finished <= finished_next;
    end
  end

  assign res.level   = lv;
  assign res.done    = finished_next;
  assign res.segment = cur_next;

  // The envelope can only finish on a tick.
  a_finish_on_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(finished) |-> $past(item_acc && kind == KIND_TICK))
    else $error("envelope finished without a tick");

endmodule

// ===== hdl/meg_outbuf.sv =====
// Result register with one skid stage on the output channel.
module meg_outbuf
  import meg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t res,
  input  logic    result_stall,
  output logic    result_valid,
  output result_t result,
  output logic    skid_valid
);

  result_t skid;
  logic    take;

  assign take = result_valid && !result_stall;

  // Occupancy of the two stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (result_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  // Payload moves.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        result <= skid;
      end
    end else if (push) begin
      if (result_valid && !take) begin
        skid <= res;
      end else begin
        result <= res;
      end
    end
  end

  // No word arrives while the skid stage is occupied.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into a full buffer");

  // The skid stage only fills behind a waiting result.
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid stage holds a word ahead of the output");

endmodule

// ===== tb/multipoint_envelope_generator_core_tb.sv =====
// Self-checking testbench for the multipoint envelope generator core.
module multipoint_envelope_generator_core_tb;
  import meg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ERROR_PRINT_CAP = 200;
  localparam longint unsigned PHASE_UNIT = 64'd1 << PHASE_FRAC_BITS;

  // One input word as it travels through the input channel.
  typedef struct packed {
    kind_t                   kind;
    logic [SEG_W-1:0]        idx;
    logic signed [LVL_W-1:0] lvl;
    logic [INC_W-1:0]        incr;
  } env_word_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    item_valid = 1'b0;
  logic                    item_stall;
  logic [1:0]              kind = '0;
  logic [SEG_W-1:0]        point_index = '0;
  logic signed [LVL_W-1:0] point_level = '0;
  logic [INC_W-1:0]        point_increment = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic signed [LVL_W-1:0] level;
  logic                    done_res;
  logic [SEG_W-1:0]        segment;
  logic                    cfg_write = 1'b0;
  logic [1:0]              cfg_index = '0;
  logic [STR_W-1:0]        cfg_data = '0;

  env_word_t   word_queue[$];
  result_t     expected_levels[$];
  env_word_t   in_flight;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned phase_words = 0;
  bit          calm = 1'b0;

  // Envelope state as the testbench predicts it.
  logic signed [LVL_W-1:0] lvl_tab [MAX_POINTS];
  logic [INC_W-1:0]        inc_tab [MAX_POINTS];
  int unsigned             cur_pt = 1;
  longint unsigned         env_phase = 0;
  logic [INC_W-1:0]        act_inc = '0;
  logic signed [LVL_W-1:0] last_lvl = '0;
  bit                      rel = 1'b0;
  bit                      ramp_pending = 1'b0;
  bit                      fin = 1'b0;

  // Register copies, starting at their reset values.
  logic [CNT_W-1:0] cfg_count = 7'd4;
  logic [SEG_W-1:0] cfg_sus = '0;
  bit               cfg_forced = 1'b0;
  logic [STR_W-1:0] cfg_stretch = 24'd65536;

  multipoint_envelope_generator_core dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .kind(kind),
    .point_index(point_index),
    .point_level(point_level),
    .point_increment(point_increment),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .level(level),
    .done_res(done_res),
    .segment(segment),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Table reads: levels beyond the table are zero, point zero always steps a whole unit.
  function automatic longint point_level_at(int unsigned i);
    return (i < MAX_POINTS) ? longint'(lvl_tab[i]) : 64'sd0;
  endfunction

  function automatic logic [INC_W-1:0] point_step_at(int unsigned i);
    if (i == 0) begin
      return INC_ONE;
    end
    return (i < MAX_POINTS) ? inc_tab[i] : '0;
  endfunction

  // Linear interpolation; the fractional part is dropped towards zero.
  function automatic longint lerp_level(longint a, longint b, longint unsigned t);
    longint p;
    longint q;
    p = (b - a) * longint'(t);
    if (p >= 0) begin
      q = p >>> PHASE_FRAC_BITS;
    end else begin
      q = -((-p) >>> PHASE_FRAC_BITS);
    end
    return a + q;
  endfunction

  // Work out the level, finish flag and point for one tick.
  task automatic envelope_tick(output result_t r);
    int unsigned     cnt;
    int unsigned     tgt;
    int unsigned     np;
    int unsigned     prv;
    longint          lv;
    longint unsigned stp;
    logic [INC_W-1:0] inc;
    cnt = cfg_count;
    if (cnt < 1) begin
      cnt = 1;
    end
    if (cnt > CNT_LIM) begin
      cnt = CNT_LIM;
    end
    if (fin) begin
      lv = point_level_at(cnt - 1);
      last_lvl = lv[LVL_W-1:0];
    end else if (cfg_sus != 0 && cur_pt == cfg_sus + 1 && !rel) begin
      lv = point_level_at(cfg_sus);
      last_lvl = lv[LVL_W-1:0];
    end else if (rel && ramp_pending) begin
      // Release ramp from the last output towards the release target.
      tgt = (cfg_sus == 0) ? cnt - 1 : cfg_sus + 1;
      inc = point_step_at(tgt);
      if (inc == 0) begin
        lv = point_level_at(tgt);
      end else begin
        lv = lerp_level(longint'(last_lvl), point_level_at(tgt), env_phase);
      end
      stp = inc;
      stp = (stp * cfg_stretch) >> 16;
      env_phase += (stp << PH_SHL) >> PH_SHR;
      if (env_phase >= PHASE_UNIT) begin
        np = (cfg_sus == 0) ? 1 : cfg_sus + 2;
        ramp_pending = 1'b0;
        env_phase = 0;
        if (np >= cnt || cfg_sus == 0) begin
          fin = 1'b1;
        end
        cur_pt = (np > 63) ? 63 : np;
        act_inc = point_step_at(cur_pt);
      end
    end else begin
      // Ordinary segment between the previous and the current point.
      prv = (cur_pt == 0) ? 0 : cur_pt - 1;
      if (act_inc >= INC_ONE) begin
        lv = point_level_at(cur_pt);
      end else begin
        lv = lerp_level(point_level_at(prv), point_level_at(cur_pt), env_phase);
      end
      stp = act_inc;
      env_phase += (stp << PH_SHL) >> PH_SHR;
      if (env_phase >= PHASE_UNIT) begin
        if (cur_pt >= cnt - 1) begin
          fin = 1'b1;
        end else begin
          cur_pt++;
        end
        env_phase = 0;
        act_inc = point_step_at(cur_pt);
      end
      last_lvl = lv[LVL_W-1:0];
    end
    r.level = lv[LVL_W-1:0];
    r.done = fin;
    r.segment = cur_pt[SEG_W-1:0];
  endtask

  // Apply one accepted word to the predicted state.
  task automatic envelope_update(input env_word_t w, output bit produced, output result_t r);
    produced = 1'b0;
    r = '0;
    case (w.kind)
      KIND_LOAD: begin
        lvl_tab[w.idx] = w.lvl;
        inc_tab[w.idx] = w.incr;
      end
      KIND_START: begin
        cur_pt = 1;
        env_phase = 0;
        rel = 1'b0;
        fin = 1'b0;
        last_lvl = '0;
        act_inc = point_step_at(1);
        ramp_pending = cfg_forced;
      end
      KIND_RELEASE: begin
        if (!rel) begin
          rel = 1'b1;
          if (ramp_pending) begin
            env_phase = 0;
          end
        end
      end
      default: begin
        envelope_tick(r);
        produced = 1'b1;
      end
    endcase
  endtask

  // Mostly steps that cross a segment in a handful of ticks, with some
  // immediate, zero and very slow ones.
  function automatic logic [INC_W-1:0] random_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      return '0;
    end else if (r < 12) begin
      return INC_W'($urandom_range(1 << 24, (1 << 25) - 1));
    end else if (r < 20) begin
      return INC_W'($urandom_range(1, 1 << 20));
    end
    return INC_W'($urandom_range(1 << 21, (1 << 24) - 1));
  endfunction

  function automatic env_word_t make_word(kind_t k);
    env_word_t w;
    w.kind = k;
    w.idx = SEG_W'($urandom_range(0, MAX_POINTS - 1));
    w.lvl = LVL_W'($urandom());
    w.incr = random_step();
    return w;
  endfunction

  task automatic push_word(env_word_t w);
    word_queue.push_back(w);
    phase_words++;
  endtask

  task automatic push_load(int unsigned i, logic [LVL_W-1:0] lv, logic [INC_W-1:0] st);
    env_word_t w;
    w = make_word(KIND_LOAD);
    w.idx = SEG_W'(i);
    w.lvl = lv;
    w.incr = st;
    push_word(w);
  endtask

  task automatic push_many(kind_t k, int unsigned n);
    repeat (n) push_word(make_word(k));
  endtask

  // A well-formed note: optional reloads, start, ticks, then mostly a release and more ticks.
  task automatic queue_envelope();
    push_many(KIND_LOAD, $urandom_range(0, 2));
    push_word(make_word(KIND_START));
    push_many(KIND_TICK, $urandom_range(1, 24));
    if ($urandom_range(0, 9) < 8) begin
      push_word(make_word(KIND_RELEASE));
      if ($urandom_range(0, 4) == 0) begin
        push_word(make_word(KIND_RELEASE));
      end
      push_many(KIND_TICK, $urandom_range(1, 24));
    end
  endtask

  // Wait until every word is taken and every result has arrived, then let
  // the block finish any table read still under way.
  task automatic wait_quiet();
    do begin
      @(negedge clk);
    end while (word_queue.size() != 0 || item_valid || expected_levels.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [STR_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_POINT_COUNT:   cfg_count = data[CNT_W-1:0];
      REG_SUSTAIN_POINT: cfg_sus = data[SEG_W-1:0];
      REG_FORCED_RELEASE: cfg_forced = data[0];
      default:           cfg_stretch = data;
    endcase
  endtask

  task automatic reconfigure(logic [CNT_W-1:0] cnt, logic [SEG_W-1:0] sus, bit forced,
                             logic [STR_W-1:0] str);
    wait_quiet();
    write_reg(REG_POINT_COUNT, STR_W'(cnt));
    write_reg(REG_SUSTAIN_POINT, STR_W'(sus));
    write_reg(REG_FORCED_RELEASE, STR_W'(forced));
    write_reg(REG_STRETCH, str);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // One random phase: mostly whole notes, some stray words.
  task automatic run_phase(logic [CNT_W-1:0] cnt, logic [SEG_W-1:0] sus, bit forced,
                           logic [STR_W-1:0] str, bit quiet);
    reconfigure(cnt, sus, forced, str);
    calm = quiet;
    phase_words = 0;
    while (phase_words < 62) begin
      if ($urandom_range(0, 99) < 85) begin
        queue_envelope();
      end else begin
        repeat ($urandom_range(1, 5)) push_word(make_word(kind_t'($urandom_range(0, 3))));
      end
    end
  endtask

  // Input side: hold a stalled word, otherwise offer the next one or idle.
  always @(posedge clk) begin : driver
    result_t res;
    bit      has_res;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        envelope_update(in_flight, has_res, res);
        if (has_res) begin
          expected_levels.push_back(res);
        end
      end
      if (!(item_valid && item_stall)) begin
        if (word_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
          in_flight = word_queue.pop_front();
          item_valid <= 1'b1;
          kind <= in_flight.kind;
          point_index <= in_flight.idx;
          point_level <= in_flight.lvl;
          point_increment <= in_flight.incr;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      error_count++;
      if (error_count <= ERROR_PRINT_CAP) begin
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  // Output side: compare each result word with the oldest prediction.
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_levels.size() == 0) begin
          error_count++;
          if (error_count <= ERROR_PRINT_CAP) begin
            $error("result word with no tick waiting: level %0d", level);
          end
        end else begin
          want = expected_levels.pop_front();
          check_field("level", longint'(want.level), longint'(level));
          check_field("done_res", longint'(want.done), longint'(done_res));
          check_field("segment", longint'(want.segment), longint'(segment));
        end
      end
      result_stall <= !calm && ($urandom_range(0, 99) < 32);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill the whole table before any tick or note start reads it.
    for (int unsigned i = 0; i < MAX_POINTS; i++) begin
      push_load(i, LVL_W'($urandom()), random_step());
    end

    // Walk a short envelope with reset settings: immediate, half and
    // oversized steps, level extremes, point zero loaded with a zero step,
    // and a second key release that must be ignored.
    push_load(1, 24'h7FFFFF, INC_ONE);
    push_load(2, 24'h800000, INC_W'(1 << 23));
    push_load(3, '0, '1);
    push_load(0, 24'h123456, '0);
    push_word(make_word(KIND_START));
    push_many(KIND_TICK, 6);
    push_many(KIND_RELEASE, 2);
    push_many(KIND_TICK, 2);

    // Sustain hold, then a forced release at full stretch.
    reconfigure(7'd3, 6'd1, 1'b1, 24'hFFFFFF);
    push_word(make_word(KIND_START));
    push_many(KIND_TICK, 4);
    push_word(make_word(KIND_RELEASE));
    push_many(KIND_TICK, 3);

    // Single point with forced release: the ramp targets point zero.
    reconfigure(7'd1, 6'd0, 1'b1, 24'd65536);
    push_word(make_word(KIND_START));
    push_many(KIND_TICK, 3);
    push_word(make_word(KIND_RELEASE));
    push_many(KIND_TICK, 3);

    // Random phases over a range of settings, extremes included.
    run_phase(7'd5, 6'd2, 1'b1, 24'd65536, 1'b0);
    run_phase(7'd1, 6'd0, 1'b1, 24'd65536, 1'b0);
    run_phase(7'd64, 6'd0, 1'b0, 24'd65536, 1'b1);
    run_phase(7'd8, 6'd63, 1'b1, 24'd0, 1'b0);
    run_phase(7'd0, 6'd0, 1'b1, 24'hFFFFFF, 1'b0);
    run_phase(7'd127, 6'd5, 1'b1, 24'h008000, 1'b1);
    run_phase(7'd6, 6'd3, 1'b1, 24'h020000, 1'b0);
    run_phase(7'd3, 6'd2, 1'b0, 24'h008000, 1'b0);
    run_phase(7'd2, 6'd1, 1'b1, 24'h00C000, 1'b0);
    run_phase(7'd7, 6'd6, 1'b1, 24'h010000, 1'b0);
    repeat (4) begin
      run_phase(CNT_W'($urandom_range(1, 10)), SEG_W'($urandom_range(0, 8)),
                bit'($urandom_range(0, 1)), STR_W'($urandom()), 1'b0);
    end

    wait_quiet();
    if (error_count == 0 && expected_levels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/meg_pkg.sv
hdl/meg_ram.sv
hdl/meg_cache.sv
hdl/meg_engine.sv
hdl/meg_outbuf.sv
hdl/multipoint_envelope_generator_core.sv
tb/multipoint_envelope_generator_core_tb.sv
